@@ hw/rtl/bba_pkg.sv @@
// Package for the block bump allocator: sizes, codes and the structs
// shared by the controller, the block store and the top level. No dependencies.
`default_nettype none
package bba_pkg;

  localparam int NUM_BLOCKS      = 16;
  localparam int BLOCK_STRIDE    = 4096;  // power of two
  localparam int MIN_BLOCK_BYTES = 64;

  localparam int ADDR_W   = 16;
  localparam int SIZE_W   = 16;
  localparam int CFG_W    = 13;
  localparam int CNT_W    = 13;
  localparam int BLK_W    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int OPEN_W   = $clog2(NUM_BLOCKS + 1);
  localparam int STRIDE_W = $clog2(BLOCK_STRIDE);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_EMPTY   = 2'd2;
  localparam logic [1:0] MODE_RELEASE = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERSIZE  = 3'd1;
  localparam logic [2:0] ST_NO_BLOCK  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW = 3'd4;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SIZE_W-1:0] alloc_size;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] granted_address;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] holders;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [BLK_W-1:0] rd_idx;
    logic             wr_en;
    logic [BLK_W-1:0] wr_idx;
    entry_t           wr_entry;
    logic             clr_all;
  } mem_cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/block_bump_allocator_top.sv @@
// Top level of the block bump allocator: sequencer plus block store.
// Depends on bba_pkg, bba_ctrl and bba_store.
//
// Usage: drive req_i and raise start; the request transfers at a clock edge
// with start high and busy low. Each request gives exactly one result: done_o
// is high for one cycle with rsp_o holding status and granted_address. The
// receiver has no way to stall; results must be taken when shown.
// Oversize, first allocate into an empty pool, empty-all, release-all and
// a free outside every block are answered with busy staying low. A free
// of an open block does one store read, then write-back. An allocate reads
// the store once for each open block it visits, newest first.
// block_size is written with cfg_we_i/cfg_wdata_i while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
// Reset clears the open-block count and the store valid bits, so every block
// reads as empty with no holders; no clearing pass is needed.
`default_nettype none
module block_bump_allocator_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire bba_pkg::req_t             req_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [bba_pkg::CFG_W-1:0] cfg_wdata_i,
  output logic                           done_o,
  output bba_pkg::rsp_t                  rsp_o
);

  bba_pkg::mem_cmd_t cmd;
  bba_pkg::entry_t   rd_entry;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (cmd),
    .rd_entry_i  (rd_entry),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  bba_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .rd_entry_o (rd_entry)
  );

endmodule
`default_nettype wire

@@ hw/rtl/bba_store.sv @@
// Block state store: one synchronous RAM of fill offset and holder count per
// block, with a valid bit per entry so a bulk clear needs no pass over the entries. Uses bba_pkg.
`default_nettype none
module bba_store (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bba_pkg::mem_cmd_t cmd_i,
  output bba_pkg::entry_t        rd_entry_o
);

  bba_pkg::entry_t                  mem_q [bba_pkg::NUM_BLOCKS];
  bba_pkg::entry_t                  rdata_q;
  logic                             rvalid_q;
  logic [bba_pkg::NUM_BLOCKS-1:0]   valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_idx] <= cmd_i.wr_entry;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (cmd_i.rd_en) begin
        rvalid_q <= valid_q[cmd_i.rd_idx];
      end
      if (cmd_i.clr_all) begin
        valid_q <= '0;
      end else if (cmd_i.wr_en) begin
        valid_q[cmd_i.wr_idx] <= 1'b1;
      end
    end
  end

  // an entry never written since the last clear reads as zero
  assign rd_entry_o = rvalid_q ? rdata_q : '0;

endmodule
`default_nettype wire

@@ hw/rtl/bba_ctrl.sv @@
// Allocator sequencer: block size register, open-block count, newest-first
// scan over the block store and the result register. Uses bba_pkg.
`default_nettype none
module bba_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire bba_pkg::req_t                req_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [bba_pkg::CFG_W-1:0]    cfg_wdata_i,
  output bba_pkg::mem_cmd_t                 cmd_o,
  input  wire bba_pkg::entry_t              rd_entry_i,
  output logic                              done_o,
  output bba_pkg::rsp_t                     rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FREE = 2'd2;

  localparam logic [bba_pkg::CFG_W-1:0] MinB = bba_pkg::CFG_W'(bba_pkg::MIN_BLOCK_BYTES);
  localparam logic [bba_pkg::CFG_W-1:0] MaxB = bba_pkg::CFG_W'(bba_pkg::BLOCK_STRIDE);
  localparam logic [bba_pkg::ADDR_W-1:0] OffMask =
      bba_pkg::ADDR_W'(bba_pkg::BLOCK_STRIDE - 1);

  logic [1:0]                    state_q, state_d;
  logic [bba_pkg::CFG_W-1:0]     bsize_q;
  logic [bba_pkg::OPEN_W-1:0]    open_q, open_d;
  logic [bba_pkg::BLK_W-1:0]     idx_q, idx_d;
  bba_pkg::req_t                 req_q, req_d;
  logic                          done_d;
  bba_pkg::rsp_t                 rsp_d;

  logic [bba_pkg::CFG_W-1:0]     clamp, es;
  logic [bba_pkg::CFG_W-1:0]     left;
  logic                          fits;
  logic [bba_pkg::ADDR_W-1:0]    fr_blk, fr_off;
  logic                          fr_hit;
  logic [bba_pkg::CNT_W-1:0]     fill_sum;
  logic [bba_pkg::CNT_W-1:0]     hold_inc, hold_dec;

  always_comb begin
    clamp = bsize_q;
    if (clamp < MinB) clamp = MinB;
    if (clamp > MaxB) clamp = MaxB;
    es = {clamp[bba_pkg::CFG_W-1:1], 1'b0};
  end

  // bytes left in the block being scanned; a shrunken size leaves none
  assign left = (rd_entry_i.fill > es) ? '0 : es - rd_entry_i.fill;
  assign fits = {{(bba_pkg::SIZE_W - bba_pkg::CFG_W){1'b0}}, left} >= req_q.alloc_size;
  assign fill_sum = rd_entry_i.fill + bba_pkg::CNT_W'(req_q.alloc_size);
  assign hold_inc = (rd_entry_i.holders < bba_pkg::CNT_MAX) ? rd_entry_i.holders + 1'b1
                                                            : rd_entry_i.holders;
  assign hold_dec = rd_entry_i.holders - 1'b1;

  assign fr_blk = req_i.address >> bba_pkg::STRIDE_W;
  assign fr_off = req_i.address & OffMask;
  assign fr_hit = (fr_blk < bba_pkg::ADDR_W'(open_q)) &&
                  (fr_off < bba_pkg::ADDR_W'(es));

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    open_d  = open_q;
    idx_d   = idx_q;
    req_d   = req_q;
    done_d  = 1'b0;
    rsp_d   = '0;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_i;
          case (req_i.mode)
            bba_pkg::MODE_ALLOC: begin
              if (req_i.alloc_size > bba_pkg::SIZE_W'(es)) begin
                done_d     = 1'b1;
                rsp_d.status = bba_pkg::ST_OVERSIZE;
              end else if (open_q == '0) begin
                // nothing open yet: open block zero at once
                cmd_o.wr_en            = 1'b1;
                cmd_o.wr_idx           = '0;
                cmd_o.wr_entry.fill    = bba_pkg::CNT_W'(req_i.alloc_size);
                cmd_o.wr_entry.holders = bba_pkg::CNT_W'(1);
                open_d                 = bba_pkg::OPEN_W'(1);
                done_d                 = 1'b1;
                rsp_d.status           = bba_pkg::ST_OK;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_idx = bba_pkg::BLK_W'(open_q - 1'b1);
                idx_d        = bba_pkg::BLK_W'(open_q - 1'b1);
                state_d      = S_SCAN;
              end
            end
            bba_pkg::MODE_FREE: begin
              if (fr_hit) begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_idx = fr_blk[bba_pkg::BLK_W-1:0];
                idx_d        = fr_blk[bba_pkg::BLK_W-1:0];
                state_d      = S_FREE;
              end else begin
                done_d       = 1'b1;
                rsp_d.status = bba_pkg::ST_NOT_FOUND;
              end
            end
            bba_pkg::MODE_EMPTY: begin
              cmd_o.clr_all = 1'b1;
              done_d        = 1'b1;
            end
            default: begin
              cmd_o.clr_all = 1'b1;
              open_d        = '0;
              done_d        = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (fits) begin
          cmd_o.wr_en            = 1'b1;
          cmd_o.wr_idx           = idx_q;
          cmd_o.wr_entry.fill    = fill_sum;
          cmd_o.wr_entry.holders = hold_inc;
          done_d                 = 1'b1;
          rsp_d.granted_address  = (bba_pkg::ADDR_W'(idx_q) << bba_pkg::STRIDE_W) +
                                   bba_pkg::ADDR_W'(rd_entry_i.fill);
          state_d                = S_IDLE;
        end else if (idx_q == '0) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (open_q < bba_pkg::OPEN_W'(bba_pkg::NUM_BLOCKS)) begin
            // open the next unused block, stale contents ignored
            cmd_o.wr_en            = 1'b1;
            cmd_o.wr_idx           = bba_pkg::BLK_W'(open_q);
            cmd_o.wr_entry.fill    = bba_pkg::CNT_W'(req_q.alloc_size);
            cmd_o.wr_entry.holders = bba_pkg::CNT_W'(1);
            open_d                 = open_q + 1'b1;
            rsp_d.granted_address  = bba_pkg::ADDR_W'(open_q) << bba_pkg::STRIDE_W;
          end else begin
            rsp_d.status = bba_pkg::ST_NO_BLOCK;
          end
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_idx = idx_q - 1'b1;
          idx_d        = idx_q - 1'b1;
        end
      end
      S_FREE: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (rd_entry_i.holders == '0) begin
          rsp_d.status = bba_pkg::ST_UNDERFLOW;
        end else begin
          cmd_o.wr_en            = 1'b1;
          cmd_o.wr_idx           = idx_q;
          cmd_o.wr_entry.holders = hold_dec;
          cmd_o.wr_entry.fill    = (hold_dec == '0) ? '0 : rd_entry_i.fill;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bsize_q <= bba_pkg::CFG_RESET;
      open_q  <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      done_o  <= done_d;
      if (cfg_we_i) begin
        bsize_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    req_q <= req_d;
    rsp_o <= rsp_d;
  end

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for block_bump_allocator_top: directed table, then random
// traffic over several block sizes, checked against an in-bench allocator predictor.
// Depends on bba_pkg and the block_bump_allocator_top RTL.
`timescale 1ns / 1ps

module tb_top;
  import bba_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned MAX_GAP        = 17;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned DRAIN_CYCLES   = NUM_BLOCKS + 4;

  typedef struct {
    req_t        req;
    int unsigned reps;
    bit          fixed;
    rsp_t        rsp;
  } plan_row_t;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  req_t             req = '0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             done;
  rsp_t             rsp;

  // predictor state
  logic [CFG_W-1:0] blk_size_cfg = CFG_RESET;
  logic [CNT_W-1:0] fill_q [NUM_BLOCKS];
  logic [CNT_W-1:0] holders_q [NUM_BLOCKS];
  int unsigned      open_cnt = 0;

  rsp_t        grant_q [$];
  logic [15:0] live_addr [$];

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned status_seen [8];
  bit          burst   = 1'b0;

  block_bump_allocator_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .done_o      (done),
    .rsp_o       (rsp)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int unsigned usable_bytes();
    int unsigned v = blk_size_cfg;
    if (v < MIN_BLOCK_BYTES) v = MIN_BLOCK_BYTES;
    if (v > BLOCK_STRIDE) v = BLOCK_STRIDE;
    return v & ~32'd1;
  endfunction

  function automatic void clear_blocks();
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      fill_q[b]    = '0;
      holders_q[b] = '0;
    end
  endfunction

  // Applies one request to the predictor state and returns the expected result.
  function automatic rsp_t alloc_predict(req_t r);
    rsp_t        o;
    int unsigned es;
    int unsigned left;
    int unsigned base;
    int unsigned pick;
    bit          hit;
    o.status          = ST_OK;
    o.granted_address = '0;
    es   = usable_bytes();
    hit  = 1'b0;
    pick = 0;
    case (r.mode)
      MODE_ALLOC: begin
        if (r.alloc_size > es) begin
          o.status = ST_OVERSIZE;
        end else begin
          for (int i = int'(open_cnt) - 1; i >= 0 && !hit; i--) begin
            left = (fill_q[i] > es) ? 0 : es - fill_q[i];
            if (left >= r.alloc_size) begin
              hit  = 1'b1;
              pick = i;
            end
          end
          if (!hit && open_cnt < NUM_BLOCKS) begin
            pick            = open_cnt;
            fill_q[pick]    = '0;
            holders_q[pick] = '0;
            open_cnt++;
            hit = 1'b1;
          end
          if (!hit) begin
            o.status = ST_NO_BLOCK;
          end else begin
            o.granted_address = 16'(pick * BLOCK_STRIDE + fill_q[pick]);
            fill_q[pick] = CNT_W'(fill_q[pick] + r.alloc_size);
            if (holders_q[pick] != CNT_MAX) holders_q[pick]++;
          end
        end
      end
      MODE_FREE: begin
        for (int i = int'(open_cnt) - 1; i >= 0 && !hit; i--) begin
          base = i * BLOCK_STRIDE;
          if (r.address >= base && r.address < base + es) begin
            hit  = 1'b1;
            pick = i;
          end
        end
        if (!hit) begin
          o.status = ST_NOT_FOUND;
        end else if (holders_q[pick] == '0) begin
          o.status = ST_UNDERFLOW;
        end else begin
          holders_q[pick]--;
          if (holders_q[pick] == '0) fill_q[pick] = '0;
        end
      end
      MODE_EMPTY: clear_blocks();
      default: begin
        open_cnt = 0;
        clear_blocks();
      end
    endcase
    return o;
  endfunction

  function automatic plan_row_t plan_row(logic [1:0] m, int unsigned sz, int unsigned ad,
                                         int unsigned n, bit fx, logic [2:0] st,
                                         int unsigned ga);
    plan_row_t p;
    p.req.mode               = m;
    p.req.alloc_size         = 16'(sz);
    p.req.address            = 16'(ad);
    p.reps                   = n;
    p.fixed                  = fx;
    p.rsp.status             = st;
    p.rsp.granted_address    = 16'(ga);
    return p;
  endfunction

  // One request transfer; the expectation is queued at the accepting edge.
  task automatic send(req_t r, bit fixed, rsp_t fixed_rsp, output rsp_t got);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    got = alloc_predict(r);
    grant_q.push_back(fixed ? fixed_rsp : got);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_block_size(logic [CFG_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we       <= 1'b0;
    blk_size_cfg  = v;
  endtask

  task automatic random_ops(int unsigned n);
    req_t        r;
    rsp_t        got;
    int unsigned es;
    int unsigned roll;
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      es           = usable_bytes();
      r.alloc_size = 16'($urandom);
      r.address    = 16'($urandom);
      roll         = $urandom_range(0, 99);
      if (roll < 50) begin
        r.mode = MODE_ALLOC;
        case ($urandom_range(0, 9))
          0:       r.alloc_size = 16'($urandom);  // mostly oversize
          1:       r.alloc_size = 16'(es - $urandom_range(0, 2) + $urandom_range(0, 1));
          2, 3:    r.alloc_size = 16'($urandom_range(0, es));
          default: r.alloc_size = 16'($urandom_range(0, es / 8));
        endcase
      end else if (roll < 92) begin
        r.mode = MODE_FREE;
        if (live_addr.size() != 0 && $urandom_range(0, 4) != 0) begin
          pick      = $urandom_range(0, live_addr.size() - 1);
          r.address = live_addr[pick];
          live_addr.delete(pick);
        end else if ($urandom_range(0, 1) == 0) begin
          // last usable byte of a block, or first byte past its usable end
          r.address = 16'($urandom_range(0, NUM_BLOCKS - 1) * BLOCK_STRIDE + es
                          - $urandom_range(0, 1));
        end
      end else if (roll < 96) begin
        r.mode = MODE_EMPTY;
      end else begin
        r.mode = MODE_RELEASE;
      end
      send(r, 1'b0, '0, got);
      if (r.mode == MODE_ALLOC && got.status == ST_OK) live_addr.push_back(got.granted_address);
      if (r.mode == MODE_EMPTY || r.mode == MODE_RELEASE) live_addr.delete();
    end
  endtask

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
  endtask

  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && done) begin
      results_seen++;
      status_seen[rsp.status]++;
      if (grant_q.size() == 0) begin
        report($sformatf("unexpected result status %0d address 0x%04h",
                         rsp.status, rsp.granted_address));
      end else begin
        want = grant_q.pop_front();
        if (rsp.status !== want.status)
          report($sformatf("status expected %0d got %0d", want.status, rsp.status));
        if (rsp.granted_address !== want.granted_address)
          report($sformatf("granted_address expected 0x%04h got 0x%04h",
                           want.granted_address, rsp.granted_address));
      end
    end
  end

  // Watchdog: cycles without any transfer in either direction.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (rst_ni) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, grant_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t                plan [$];
    rsp_t                     got;
    logic [CFG_W-1:0]         sizes [$];
    clear_blocks();
    foreach (status_seen[s]) status_seen[s] = 0;
    // Reset block size is 4096: a full block is 4096 bytes.
    plan = '{
      plan_row(MODE_ALLOC,   0,      16'hFFFF, 1,  1, ST_OK,        0),
      plan_row(MODE_ALLOC,   4097,   0,        1,  1, ST_OVERSIZE,  0),
      plan_row(MODE_ALLOC,   16'hFFFF, 16'hFFFF, 1, 1, ST_OVERSIZE, 0),
      plan_row(MODE_ALLOC,   4096,   0,        1,  1, ST_OK,        0),
      plan_row(MODE_ALLOC,   1,      0,        1,  1, ST_OK,        16'h1000),
      plan_row(MODE_FREE,    0,      16'hFFFF, 1,  1, ST_NOT_FOUND, 0),
      plan_row(MODE_FREE,    0,      16'h2000, 1,  1, ST_NOT_FOUND, 0),
      plan_row(MODE_FREE,    16'hFFFF, 16'h0FFF, 1, 1, ST_OK,       0),
      plan_row(MODE_FREE,    0,      16'h1000, 1,  1, ST_OK,        0),
      plan_row(MODE_FREE,    0,      16'h1FFF, 1,  1, ST_UNDERFLOW, 0),
      plan_row(MODE_EMPTY,   16'hFFFF, 16'hFFFF, 1, 1, ST_OK,       0),
      plan_row(MODE_FREE,    0,      0,        1,  1, ST_UNDERFLOW, 0),
      plan_row(MODE_RELEASE, 16'hFFFF, 16'hFFFF, 1, 1, ST_OK,       0),
      plan_row(MODE_FREE,    0,      0,        1,  1, ST_NOT_FOUND, 0),
      plan_row(MODE_ALLOC,   100,    0,        1,  1, ST_OK,        0),
      plan_row(MODE_ALLOC,   4096,   0,        15, 0, ST_OK,        0),
      plan_row(MODE_ALLOC,   3997,   0,        1,  1, ST_NO_BLOCK,  0),
      plan_row(MODE_ALLOC,   3996,   0,        1,  0, ST_OK,        0),
      plan_row(MODE_FREE,    0,      16'hFFFF, 1,  1, ST_OK,        0),
      plan_row(MODE_FREE,    0,      16'hFFFF, 1,  1, ST_UNDERFLOW, 0),
      plan_row(MODE_ALLOC,   0,      0,        1,  0, ST_OK,        0),
      plan_row(MODE_RELEASE, 0,      0,        1,  1, ST_OK,        0)
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[p])
      repeat (plan[p].reps) send(plan[p].req, plan[p].fixed, plan[p].rsp, got);

    // State carries across size changes, so shrunken blocks get exercised too.
    sizes = '{13'h1FFF, 13'd0, 13'd65, 13'd4095, 13'd64,
              CFG_W'($urandom_range(0, 8191)), 13'd130, CFG_RESET};
    foreach (sizes[s]) begin
      write_block_size(sizes[s]);
      random_ops(PHASE_ITEMS);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests over %0d cycles, %0d results checked, %0d mismatches",
             items_sent, cycle_cnt, results_seen, mismatches);
    $display("status mix: ok %0d, oversize %0d, pool full %0d, not found %0d, underflow %0d",
             status_seen[ST_OK], status_seen[ST_OVERSIZE], status_seen[ST_NO_BLOCK],
             status_seen[ST_NOT_FOUND], status_seen[ST_UNDERFLOW]);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/bba_pkg.sv
hw/rtl/bba_store.sv
hw/rtl/bba_ctrl.sv
hw/rtl/block_bump_allocator_top.sv
sim/tb_top.sv
